FILE: src/mqtt_control_header_parser_defines.svh
// Assertion macros used by the parser FSM (mqtt_hdr_fsm).
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef MQTT_CONTROL_HEADER_PARSER_DEFINES_SVH
`define MQTT_CONTROL_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MQTT_HDR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MQTT_HDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mqtt_hdr_pkg.sv
// Shared types, codes and helper functions of the MQTT fixed-header parser.
// Depends on nothing; all parser modules refer to it by scoped names.
package mqtt_hdr_pkg;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_LEN  = 3'b010,
		PH_CONN = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_TYPE  = 3'd1,
		ST_BAD_LEN   = 3'd2,
		ST_BAD_PUB   = 3'd3,
		ST_BAD_CONN  = 3'd4,
		ST_BAD_CREDS = 3'd5,
		ST_BAD_WILL  = 3'd6,
		ST_RESERVED  = 3'd7
	} status_t;

	localparam logic [3:0] KIND_NONE        = 4'd0;
	localparam logic [3:0] KIND_CONNECT     = 4'd1;
	localparam logic [3:0] KIND_PUBLISH     = 4'd3;
	localparam logic [3:0] KIND_PUBREL      = 4'd6;
	localparam logic [3:0] KIND_SUBSCRIBE   = 4'd8;
	localparam logic [3:0] KIND_UNSUBSCRIBE = 4'd10;
	localparam logic [3:0] KIND_RESERVED_HI = 4'd15;

	localparam logic [3:0]  FLAGS_SUB_STYLE = 4'b0010;
	localparam logic [27:0] CONNECT_MIN_LEN = 28'd10;

	// Positions within the CONNECT variable header.
	localparam logic [3:0] HDR_NAME_END = 4'd6;
	localparam logic [3:0] HDR_LEVEL    = 4'd6;
	localparam logic [3:0] HDR_FLAGS    = 4'd7;
	localparam logic [3:0] HDR_KA_HIGH  = 4'd8;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} beat_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  status;
		logic [27:0] rem_len;
		logic        dup;
		logic [1:0]  qos;
		logic        retain;
		logic [7:0]  version;
		logic        clean;
		logic        will;
		logic        creds;
		logic [15:0] keep;
	} result_t;

	// Expected protocol-name bytes: length 00 04 then "MQTT".
	function automatic logic [7:0] name_byte(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0: v = 8'h00;
			4'd1: v = 8'h04;
			4'd2: v = 8'h4D;
			4'd3: v = 8'h51;
			default: v = 8'h54;
		endcase
		return v;
	endfunction

	// Builds the result beat from the packet state as it stands after the current byte.
	function automatic result_t make_result(
		input logic [3:0]  kind,
		input status_t     st,
		input logic [27:0] len,
		input logic [3:0]  pub,
		input logic [7:0]  ver,
		input logic [7:0]  cb,
		input logic [15:0] keep
	);
		result_t r;
		r         = '0;
		r.kind    = kind;
		r.status  = st;
		r.rem_len = (st == ST_BAD_LEN) ? 28'd0 : len;
		if (kind == KIND_PUBLISH) begin
			r.dup    = pub[3];
			r.qos    = pub[2:1];
			r.retain = pub[0];
		end else if (kind == KIND_CONNECT) begin
			r.qos     = (cb[2] && (cb[4:3] != 2'd3)) ? cb[4:3] : 2'd0;
			r.retain  = cb[2] & cb[5];
			r.version = ver;
			r.clean   = cb[1];
			r.will    = cb[2];
			r.creds   = cb[7] & cb[6];
			r.keep    = keep;
		end
		return r;
	endfunction

endpackage

FILE: src/mqtt_hdr_in_stage.sv
// Input register of the parser: holds one byte beat until the parse logic takes it.
// Depends on mqtt_hdr_pkg.
module mqtt_hdr_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                packet_start,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                advance,
	output mqtt_hdr_pkg::beat_t beat,
	output logic                beat_valid
);

	mqtt_hdr_pkg::beat_t beat_s1;
	logic                valid_s1;

	// The slot is free when empty or when its beat is consumed this cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1.data  <= data_byte;
			beat_s1.start <= packet_start;
		end
	end

	assign beat       = beat_s1;
	assign beat_valid = valid_s1;

endmodule

FILE: src/mqtt_hdr_fsm.sv
// Parse state and per-byte decision logic of the fixed-header parser.
// Depends on mqtt_hdr_pkg and mqtt_control_header_parser_defines.svh.
`include "mqtt_control_header_parser_defines.svh"

module mqtt_hdr_fsm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mqtt_hdr_pkg::beat_t   beat,
	input  logic                  beat_valid,
	input  logic                  advance,
	output logic                  emit,
	output mqtt_hdr_pkg::result_t result
);

	mqtt_hdr_pkg::phase_t  phase_q, nxt_phase;
	logic [3:0]            kind_q, nxt_kind;
	logic [27:0]           len_q, nxt_len;
	logic [1:0]            cnt_q, nxt_cnt;
	logic [3:0]            idx_q, nxt_idx;
	logic [3:0]            pub_q, nxt_pub;
	logic [7:0]            ver_q, nxt_ver;
	logic [7:0]            cb_q, nxt_cb;
	logic [7:0]            kah_q, nxt_kah;
	mqtt_hdr_pkg::status_t st;
	logic [15:0]           keep;
	logic [27:0]           len_part;
	logic [3:0]            typ;
	logic [3:0]            flg;
	logic                  sub_style;
	logic                  type_ok;

	assign typ       = beat.data[7:4];
	assign flg       = beat.data[3:0];
	assign sub_style = (typ == mqtt_hdr_pkg::KIND_PUBREL) ||
		(typ == mqtt_hdr_pkg::KIND_SUBSCRIBE) || (typ == mqtt_hdr_pkg::KIND_UNSUBSCRIBE);
	assign type_ok   = sub_style ? (flg == mqtt_hdr_pkg::FLAGS_SUB_STYLE) :
		((typ != mqtt_hdr_pkg::KIND_NONE) && (typ != mqtt_hdr_pkg::KIND_RESERVED_HI) &&
		(flg == 4'd0));

	// Seven payload bits of a length byte placed at their digit position.
	always_comb begin
		case (cnt_q)
			2'd0:    len_part = {21'd0, beat.data[6:0]};
			2'd1:    len_part = {14'd0, beat.data[6:0], 7'd0};
			2'd2:    len_part = {7'd0, beat.data[6:0], 14'd0};
			default: len_part = {beat.data[6:0], 21'd0};
		endcase
	end

	always_comb begin
		nxt_phase = phase_q;
		nxt_kind  = kind_q;
		nxt_len   = len_q;
		nxt_cnt   = cnt_q;
		nxt_idx   = idx_q;
		nxt_pub   = pub_q;
		nxt_ver   = ver_q;
		nxt_cb    = cb_q;
		nxt_kah   = kah_q;
		emit      = 1'b0;
		st        = mqtt_hdr_pkg::ST_OK;
		keep      = 16'd0;
		if (beat_valid) begin
			if (beat.start) begin
				// A control byte restarts the parse from a clean slate.
				nxt_phase = mqtt_hdr_pkg::PH_IDLE;
				nxt_kind  = mqtt_hdr_pkg::KIND_NONE;
				nxt_len   = 28'd0;
				nxt_cnt   = 2'd0;
				nxt_idx   = 4'd0;
				nxt_pub   = 4'd0;
				nxt_ver   = 8'd0;
				nxt_cb    = 8'd0;
				nxt_kah   = 8'd0;
				if (typ == mqtt_hdr_pkg::KIND_PUBLISH) begin
					nxt_kind = mqtt_hdr_pkg::KIND_PUBLISH;
					if ((flg[2:1] == 2'd3) || ((flg[2:1] == 2'd0) && flg[3])) begin
						emit = 1'b1;
						st   = mqtt_hdr_pkg::ST_BAD_PUB;
					end else begin
						nxt_pub   = flg;
						nxt_phase = mqtt_hdr_pkg::PH_LEN;
					end
				end else if (type_ok) begin
					nxt_kind  = typ;
					nxt_phase = mqtt_hdr_pkg::PH_LEN;
				end else begin
					emit = 1'b1;
					st   = mqtt_hdr_pkg::ST_BAD_TYPE;
				end
			end else begin
				case (phase_q)
					mqtt_hdr_pkg::PH_LEN: begin
						nxt_len = len_q | len_part;
						if (beat.data[7]) begin
							if (cnt_q == 2'd3) begin
								emit = 1'b1;
								st   = mqtt_hdr_pkg::ST_BAD_LEN;
							end else begin
								nxt_cnt = cnt_q + 2'd1;
							end
						end else if (kind_q != mqtt_hdr_pkg::KIND_CONNECT) begin
							emit = 1'b1;
						end else if (nxt_len < mqtt_hdr_pkg::CONNECT_MIN_LEN) begin
							emit = 1'b1;
							st   = mqtt_hdr_pkg::ST_BAD_CONN;
						end else begin
							nxt_phase = mqtt_hdr_pkg::PH_CONN;
							nxt_idx   = 4'd0;
						end
					end
					mqtt_hdr_pkg::PH_CONN: begin
						nxt_idx = idx_q + 4'd1;
						if (idx_q < mqtt_hdr_pkg::HDR_NAME_END) begin
							if (beat.data != mqtt_hdr_pkg::name_byte(idx_q)) begin
								emit = 1'b1;
								st   = mqtt_hdr_pkg::ST_BAD_CONN;
							end
						end else if (idx_q == mqtt_hdr_pkg::HDR_LEVEL) begin
							nxt_ver = beat.data;
						end else if (idx_q == mqtt_hdr_pkg::HDR_FLAGS) begin
							nxt_cb = beat.data;
							// Checked in priority order; the first failure wins.
							if (beat.data[7] && !beat.data[6]) begin
								emit = 1'b1;
								st   = mqtt_hdr_pkg::ST_BAD_CREDS;
							end else if (!beat.data[2] && (beat.data[5:3] != 3'd0)) begin
								emit = 1'b1;
								st   = mqtt_hdr_pkg::ST_BAD_WILL;
							end else if (beat.data[0]) begin
								emit = 1'b1;
								st   = mqtt_hdr_pkg::ST_RESERVED;
							end
						end else if (idx_q == mqtt_hdr_pkg::HDR_KA_HIGH) begin
							nxt_kah = beat.data;
						end else begin
							emit = 1'b1;
							keep = {kah_q, beat.data};
						end
					end
					default: begin
					end
				endcase
			end
			if (emit) begin
				nxt_phase = mqtt_hdr_pkg::PH_IDLE;
			end
		end
	end

	assign result = mqtt_hdr_pkg::make_result(nxt_kind, st, nxt_len, nxt_pub, nxt_ver,
		nxt_cb, keep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mqtt_hdr_pkg::PH_IDLE;
			kind_q  <= 4'd0;
			len_q   <= 28'd0;
			cnt_q   <= 2'd0;
			idx_q   <= 4'd0;
			pub_q   <= 4'd0;
			ver_q   <= 8'd0;
			cb_q    <= 8'd0;
			kah_q   <= 8'd0;
		end else if (advance) begin
			phase_q <= nxt_phase;
			kind_q  <= nxt_kind;
			len_q   <= nxt_len;
			cnt_q   <= nxt_cnt;
			idx_q   <= nxt_idx;
			pub_q   <= nxt_pub;
			ver_q   <= nxt_ver;
			cb_q    <= nxt_cb;
			kah_q   <= nxt_kah;
		end
	end

	`MQTT_HDR_ASSERT_NEXT(a_idle_after_result, advance && emit,
		phase_q == mqtt_hdr_pkg::PH_IDLE, "parser not idle after a result")
	`MQTT_HDR_ASSERT_NOW(a_bad_type_kind, emit && (st == mqtt_hdr_pkg::ST_BAD_TYPE),
		result.kind == mqtt_hdr_pkg::KIND_NONE, "bad type result carries a kind")
	`MQTT_HDR_ASSERT_NOW(a_keep_only_ok_connect, emit && (result.keep != 16'd0),
		(st == mqtt_hdr_pkg::ST_OK) && (result.kind == mqtt_hdr_pkg::KIND_CONNECT),
		"keep alive reported outside a good CONNECT")
	`MQTT_HDR_ASSERT_NOW(a_idle_no_result, beat_valid && !beat.start &&
		(phase_q == mqtt_hdr_pkg::PH_IDLE), !emit, "result from a byte while idle")

endmodule

FILE: src/mqtt_hdr_out_stage.sv
// Result register of the parser: holds one result beat until the consumer takes it.
// Depends on mqtt_hdr_pkg.
module mqtt_hdr_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  mqtt_hdr_pkg::result_t result,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mqtt_hdr_pkg::result_t held
);

	mqtt_hdr_pkg::result_t res_s2;
	logic                  valid_s2;

	assign free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign held      = res_s2;

endmodule

FILE: src/mqtt_control_header_parser.sv
// MQTT fixed-header parser, top level. A byte's result, if any, passes through the input
// register, then the result register, before it shows as out_valid.
// Throughput: one byte per cycle, sustained while the result side keeps up.
// Reset (arst_n, asynchronous, active low) empties both registers and returns the parser
// to idle with all packet state cleared; no memory needs clearing.
// Depends on mqtt_hdr_pkg, mqtt_hdr_in_stage, mqtt_hdr_fsm and mqtt_hdr_out_stage.
module mqtt_control_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        packet_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  packet_kind,
	output logic [2:0]  status,
	output logic [27:0] remaining_length,
	output logic        dup_flag,
	output logic [1:0]  qos_level,
	output logic        retain_flag,
	output logic [7:0]  protocol_version,
	output logic        clean_session,
	output logic        will_flag,
	output logic        credentials,
	output logic [15:0] keep_alive
);

	// The input register holds one byte beat. The parse logic consumes it (advance)
	// whenever the result register can take a new beat, which is every cycle unless
	// a result is stalled at the output. A consumed byte updates the packet state and,
	// at the end of the header or at the first error, loads one result beat.
	mqtt_hdr_pkg::beat_t   beat;
	mqtt_hdr_pkg::result_t result;
	mqtt_hdr_pkg::result_t held;
	logic                  beat_valid;
	logic                  emit;
	logic                  out_free;
	logic                  advance;

	assign advance = beat_valid && out_free;

	mqtt_hdr_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.packet_start (packet_start),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.advance      (advance),
		.beat         (beat),
		.beat_valid   (beat_valid)
	);

	// Packet state and the per-byte classification and checking logic.
	mqtt_hdr_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat),
		.beat_valid (beat_valid),
		.advance    (advance),
		.emit       (emit),
		.result     (result)
	);

	// The result register is reloaded in the same cycle its beat is taken, so a
	// stream of results still moves at one per cycle.
	mqtt_hdr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.result    (result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.held      (held)
	);

	assign packet_kind      = held.kind;
	assign status           = held.status;
	assign remaining_length = held.rem_len;
	assign dup_flag         = held.dup;
	assign qos_level        = held.qos;
	assign retain_flag      = held.retain;
	assign protocol_version = held.version;
	assign clean_session    = held.clean;
	assign will_flag        = held.will;
	assign credentials      = held.creds;
	assign keep_alive       = held.keep;

endmodule

FILE: tb/sv/mqtt_control_header_parser_checker.sv
// Result checker for the MQTT fixed-header parser: follows every accepted input byte,
// predicts the header results and compares each accepted result with the oldest one.
// Depends on mqtt_hdr_pkg for the result layout, status codes, kinds and phases.
`timescale 1ns / 100ps

module mqtt_control_header_parser_checker
	import mqtt_hdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        packet_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  packet_kind,
	input  logic [2:0]  status,
	input  logic [27:0] remaining_length,
	input  logic        dup_flag,
	input  logic [1:0]  qos_level,
	input  logic        retain_flag,
	input  logic [7:0]  protocol_version,
	input  logic        clean_session,
	input  logic        will_flag,
	input  logic        credentials,
	input  logic [15:0] keep_alive,
	output int          mismatch_count,
	output int          awaiting_count
);

	localparam logic [7:0] PROTO_NAME [0:5] = '{8'h00, 8'h04, "M", "Q", "T", "T"};

	phase_t      parse_phase;
	logic [3:0]  kind_reg;
	logic [27:0] len_acc;
	logic [1:0]  len_count;
	logic [3:0]  hdr_idx;
	logic [3:0]  pub_flags;
	logic [7:0]  level_reg;
	logic [7:0]  conn_flags;
	logic [7:0]  keep_hi;
	result_t     header_results_q[$];

	function automatic void clear_packet_state();
		parse_phase = PH_IDLE;
		kind_reg    = KIND_NONE;
		len_acc     = '0;
		len_count   = '0;
		hdr_idx     = '0;
		pub_flags   = '0;
		level_reg   = '0;
		conn_flags  = '0;
		keep_hi     = '0;
	endfunction

	function automatic result_t header_summary(input status_t st, input logic [15:0] keep);
		result_t r;
		r         = '0;
		r.kind    = kind_reg;
		r.status  = st;
		r.rem_len = (st == ST_BAD_LEN) ? 28'd0 : len_acc;
		if (kind_reg == KIND_PUBLISH) begin
			r.dup    = pub_flags[3];
			r.qos    = pub_flags[2:1];
			r.retain = pub_flags[0];
		end else if (kind_reg == KIND_CONNECT) begin
			// Will QoS and retain only mean something when the will flag is set.
			r.qos     = (conn_flags[2] && conn_flags[4:3] != 2'd3) ? conn_flags[4:3] : 2'd0;
			r.retain  = conn_flags[2] & conn_flags[5];
			r.version = level_reg;
			r.clean   = conn_flags[1];
			r.will    = conn_flags[2];
			r.creds   = conn_flags[7] & conn_flags[6];
			r.keep    = keep;
		end
		return r;
	endfunction

	function automatic void finish_header(input status_t st, input logic [15:0] keep);
		header_results_q.push_back(header_summary(st, keep));
		parse_phase = PH_IDLE;
	endfunction

	function automatic void predict_beat(input logic [7:0] b, input logic first);
		logic [3:0] ptype;
		logic [3:0] idx;
		logic       pair_style;
		ptype      = b[7:4];
		pair_style = (ptype == KIND_PUBREL || ptype == KIND_SUBSCRIBE ||
			ptype == KIND_UNSUBSCRIBE);
		if (first) begin
			clear_packet_state();
			if (ptype == KIND_PUBLISH) begin
				kind_reg = KIND_PUBLISH;
				if (b[2:1] == 2'd3 || (b[2:1] == 2'd0 && b[3])) begin
					finish_header(ST_BAD_PUB, 16'd0);
				end else begin
					pub_flags   = b[3:0];
					parse_phase = PH_LEN;
				end
			end else if (pair_style ? (b[3:0] == FLAGS_SUB_STYLE) :
				(ptype != KIND_NONE && ptype != KIND_RESERVED_HI && b[3:0] == 4'd0)) begin
				kind_reg    = ptype;
				parse_phase = PH_LEN;
			end else begin
				kind_reg = KIND_NONE;
				finish_header(ST_BAD_TYPE, 16'd0);
			end
		end else if (parse_phase == PH_LEN) begin
			len_acc = len_acc | (28'(b[6:0]) << (7 * len_count));
			if (b[7]) begin
				if (len_count == 2'd3)
					finish_header(ST_BAD_LEN, 16'd0);
				else
					len_count = len_count + 2'd1;
			end else if (kind_reg != KIND_CONNECT) begin
				finish_header(ST_OK, 16'd0);
			end else if (len_acc < CONNECT_MIN_LEN) begin
				finish_header(ST_BAD_CONN, 16'd0);
			end else begin
				parse_phase = PH_CONN;
				hdr_idx     = '0;
			end
		end else if (parse_phase == PH_CONN) begin
			idx     = hdr_idx;
			hdr_idx = hdr_idx + 4'd1;
			if (idx < HDR_LEVEL) begin
				if (b != PROTO_NAME[idx[2:0]])
					finish_header(ST_BAD_CONN, 16'd0);
			end else if (idx == HDR_LEVEL) begin
				level_reg = b;
			end else if (idx == HDR_FLAGS) begin
				conn_flags = b;
				if (b[7] && !b[6])
					finish_header(ST_BAD_CREDS, 16'd0);
				else if (!b[2] && b[5:3] != 3'd0)
					finish_header(ST_BAD_WILL, 16'd0);
				else if (b[0])
					finish_header(ST_RESERVED, 16'd0);
			end else if (idx == HDR_KA_HIGH) begin
				keep_hi = b;
			end else begin
				finish_header(ST_OK, {keep_hi, b});
			end
		end
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("kind=%0d status=%0d len=%0d dup=%0d qos=%0d retain=%0d ver=%0d %s",
			r.kind, r.status, r.rem_len, r.dup, r.qos, r.retain, r.version,
			$sformatf("clean=%0d will=%0d creds=%0d keep=%0d", r.clean, r.will, r.creds,
			r.keep));
	endfunction

	function automatic void check_result();
		result_t got;
		result_t want;
		got.kind    = packet_kind;
		got.status  = status;
		got.rem_len = remaining_length;
		got.dup     = dup_flag;
		got.qos     = qos_level;
		got.retain  = retain_flag;
		got.version = protocol_version;
		got.clean   = clean_session;
		got.will    = will_flag;
		got.creds   = credentials;
		got.keep    = keep_alive;
		if (header_results_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: result with nothing pending: %s", $realtime, describe(got));
		end else begin
			want = header_results_q.pop_front();
			if (got.kind !== want.kind || got.status !== want.status ||
				got.rem_len !== want.rem_len || got.dup !== want.dup ||
				got.qos !== want.qos || got.retain !== want.retain ||
				got.version !== want.version || got.clean !== want.clean ||
				got.will !== want.will || got.creds !== want.creds ||
				got.keep !== want.keep) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_packet_state();
			header_results_q.delete();
			mismatch_count = 0;
		end else begin
			// A result leaves only after its byte has passed the input and result registers,
			// so the output side is handled first.
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				predict_beat(data_byte, packet_start);
		end
		awaiting_count = header_results_q.size();
	end

endmodule

FILE: tb/sv/mqtt_control_header_parser_tb.sv
// Top of the MQTT fixed-header parser testbench: clock, reset, byte stimulus and the
// result-side stall pattern. Depends on mqtt_hdr_pkg, the parser RTL and the checker.
`timescale 1ns / 100ps

module mqtt_control_header_parser_tb;
	import mqtt_hdr_pkg::*;

	// Kinds that the stimulus needs but the package does not name.
	localparam logic [3:0] KIND_CONNACK = 4'd2;
	localparam logic [3:0] KIND_PINGREQ = 4'd12;
	localparam logic [7:0] PROTOCOL_LEVEL = 8'd4;
	localparam logic [7:0] PROTO_NAME [0:5] = '{8'h00, 8'h04, "M", "Q", "T", "T"};
	// Input beats after which the random part stops.
	localparam int HEADER_BYTES = 1950;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        packet_start;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  packet_kind;
	logic [2:0]  status;
	logic [27:0] remaining_length;
	logic        dup_flag;
	logic [1:0]  qos_level;
	logic        retain_flag;
	logic [7:0]  protocol_version;
	logic        clean_session;
	logic        will_flag;
	logic        credentials;
	logic [15:0] keep_alive;
	int          mismatch_count;
	int          awaiting_count;

	// Sender burst control and the receiver stall pattern.
	int unsigned burst_left;
	int unsigned gap_max;
	int unsigned bytes_sent;
	logic [15:0] stall_pattern = 16'hFFFF;
	logic [5:0]  stall_age = 6'd0;
	logic [7:0]  packet_bytes[$];

	mqtt_control_header_parser dut (.*);

	mqtt_control_header_parser_checker header_check (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// The receiver runs a 16-bit ready pattern that is rotated every cycle and
	// replaced when stall_age wraps. Patterns range from always ready, through random
	// ones, to a single ready bit.
	always @(posedge clk) begin
		out_ready <= stall_pattern[0];
		if (stall_age == 6'd63) begin
			case ($urandom_range(3))
				0: stall_pattern <= 16'hFFFF;
				1: stall_pattern <= 16'($urandom) | 16'h0101;
				2: stall_pattern <= 16'($urandom) | 16'($urandom) | 16'h0001;
				default: stall_pattern <= 16'h0001;
			endcase
		end else begin
			stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
		end
		stall_age <= stall_age + 6'd1;
	end

	// Presents one beat and holds it until the parser takes it. At the end of a burst
	// the sender first drops valid for a random gap; a gap of zero keeps valid high,
	// so back-to-back beats never lower and raise valid within one time step.
	task automatic send_beat(input logic [7:0] b, input logic first);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		in_valid     <= 1'b1;
		data_byte    <= b;
		packet_start <= first;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
	endtask

	// Sends the bytes built up in packet_bytes, the first one flagged as packet start.
	task automatic send_packet();
		foreach (packet_bytes[i])
			send_beat(packet_bytes[i], i == 0);
	endtask

	// Payload or noise bytes without a start flag; the parser ignores these once the
	// header has ended.
	task automatic send_filler(input int unsigned count);
		repeat (count)
			send_beat(8'($urandom), 1'b0);
	endtask

	// Appends a remaining-length field. Most are a single byte; a few run to the
	// four-byte limit, and a few overflow it with a continuation bit on the fourth
	// byte. For CONNECT a single-byte length is mostly large enough for the header.
	task automatic push_length(input logic for_connect);
		int unsigned pick;
		int unsigned count;
		pick = $urandom_range(99);
		if (pick < 3) begin
			repeat (4)
				packet_bytes.push_back(8'($urandom_range(128, 255)));
			packet_bytes.push_back(8'($urandom));
		end else begin
			count = (pick < 75) ? 1 : (pick < 88) ? 2 : (pick < 95) ? 3 : 4;
			repeat (count - 1)
				packet_bytes.push_back(8'($urandom_range(128, 255)));
			if (count == 1 && for_connect && $urandom_range(9) != 0)
				packet_bytes.push_back(8'($urandom_range(10, 127)));
			else
				packet_bytes.push_back(8'($urandom_range(0, 127)));
		end
	endtask

	// A CONNECT that is mostly well formed, so that the parse reaches the flags and
	// keep-alive bytes. Each part is corrupted now and then, and a few packets are
	// cut short so that the next start lands in the middle of a header.
	task automatic build_connect();
		logic [7:0]  cflags;
		int unsigned keep_bytes;
		packet_bytes.push_back({KIND_CONNECT, ($urandom_range(9) == 0) ? 4'($urandom) : 4'h0});
		push_length(1'b1);
		for (int k = 0; k < 6; k++)
			packet_bytes.push_back(($urandom_range(29) == 0) ? 8'($urandom) : PROTO_NAME[k]);
		packet_bytes.push_back(($urandom_range(4) == 0) ? 8'($urandom) : PROTOCOL_LEVEL);
		if ($urandom_range(3) == 0) begin
			cflags = 8'($urandom);
		end else begin
			// Legal flags: will QoS and retain only with the will flag, a username
			// only with a password, reserved bit clear.
			cflags    = 8'h00;
			cflags[1] = 1'($urandom);
			cflags[2] = 1'($urandom);
			if (cflags[2])
				cflags[5:3] = 3'($urandom);
			cflags[6] = 1'($urandom);
			cflags[7] = cflags[6] & 1'($urandom);
		end
		packet_bytes.push_back(cflags);
		packet_bytes.push_back(8'($urandom));
		packet_bytes.push_back(8'($urandom));
		if ($urandom_range(19) == 0) begin
			keep_bytes = $urandom_range(1, packet_bytes.size() - 1);
			while (packet_bytes.size() > keep_bytes)
				void'(packet_bytes.pop_back());
		end
	endtask

	task automatic random_packet();
		int unsigned pick;
		logic [3:0]  ptype;
		logic [3:0]  nibble;
		logic        pair_style;
		// Now and then the sender changes how idle it is, from none at all to long gaps.
		if ($urandom_range(15) == 0) begin
			case ($urandom_range(3))
				0: gap_max = 0;
				1: gap_max = 2;
				2: gap_max = 6;
				default: gap_max = 20;
			endcase
		end
		packet_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 40) begin
			build_connect();
		end else if (pick < 65) begin
			// Any flag nibble: QoS 3 and dup without QoS come up often enough.
			packet_bytes.push_back({KIND_PUBLISH, 4'($urandom)});
			push_length(1'b0);
		end else if (pick < 88) begin
			ptype      = 4'($urandom);
			pair_style = (ptype == KIND_PUBREL || ptype == KIND_SUBSCRIBE ||
				ptype == KIND_UNSUBSCRIBE);
			if ($urandom_range(7) != 0)
				nibble = pair_style ? FLAGS_SUB_STYLE : 4'h0;
			else
				nibble = 4'($urandom);
			packet_bytes.push_back({ptype, nibble});
			push_length(1'b0);
		end else begin
			// Raw noise with a start flag on about a quarter of the bytes.
			repeat ($urandom_range(1, 6))
				send_beat(8'($urandom), $urandom_range(3) == 0);
		end
		if (packet_bytes.size() != 0) begin
			send_packet();
			send_filler($urandom_range(0, 3));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_byte     = 8'h00;
		packet_start  = 1'b0;
		burst_left    = 0;
		gap_max       = 0;
		bytes_sent    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A byte with no start while idle is dropped without a result.
		send_beat(8'hFF, 1'b0);
		// Reserved types 0 and 15 are rejected at the control byte.
		packet_bytes = '{{KIND_NONE, 4'h0}};
		send_packet();
		packet_bytes = '{{KIND_RESERVED_HI, 4'h0}};
		send_packet();
		// PUBLISH with QoS 3, then PUBLISH with dup set at QoS 0.
		packet_bytes = '{{KIND_PUBLISH, 4'b0110}};
		send_packet();
		packet_bytes = '{{KIND_PUBLISH, 4'b1000}};
		send_packet();
		// Shortest legal packet, zero remaining length.
		packet_bytes = '{{KIND_PINGREQ, 4'h0}, 8'h00};
		send_packet();
		// SUBSCRIBE without its mandatory flag nibble.
		packet_bytes = '{{KIND_SUBSCRIBE, 4'h0}};
		send_packet();
		// PUBLISH with dup, QoS 2, retain and the largest four-byte length.
		packet_bytes = '{{KIND_PUBLISH, 4'b1101}, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
		send_packet();
		// Continuation bit still set on the fourth length byte.
		packet_bytes = '{{KIND_UNSUBSCRIBE, FLAGS_SUB_STYLE}, 8'h80, 8'h80, 8'h80, 8'h80};
		send_packet();
		// A start in the middle of a parse drops the old packet without a result.
		packet_bytes = '{{KIND_PUBREL, FLAGS_SUB_STYLE}};
		send_packet();
		packet_bytes = '{{KIND_CONNACK, 4'h0}, 8'h02};
		send_packet();
		// CONNECT too short for its variable header, then one with a bad name length.
		packet_bytes = '{{KIND_CONNECT, 4'h0}, 8'h05};
		send_packet();
		packet_bytes = '{{KIND_CONNECT, 4'h0}, 8'h0C, 8'h01};
		send_packet();
		// Complete CONNECT at the minimum length, level 5 (reported, not rejected),
		// every flag but the reserved bit, so will QoS reads as 3 and reports 0.
		packet_bytes = '{{KIND_CONNECT, 4'h0}, 8'd10, PROTO_NAME[0], PROTO_NAME[1],
			PROTO_NAME[2], PROTO_NAME[3], PROTO_NAME[4], PROTO_NAME[5], 8'd5, 8'hFE,
			8'h12, 8'h34};
		send_packet();

		while (bytes_sent < HEADER_BYTES)
			random_packet();
		in_valid <= 1'b0;

		// Drain: wait for every predicted result, then wait on so that any stray result
		// in the input or result register would still be caught.
		@(posedge clk);
		while (awaiting_count != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && awaiting_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
